// ----- hdl/ictf_pkg.sv -----
// Shared types, constants and helper functions of the tilt filter.
package ictf_pkg;

    localparam int NUM_REGS   = 6;
    localparam int CORDIC_DEF = 16;
    localparam int TAB_LEN    = 24;

    localparam logic [2:0] REG_GYRO_X  = 3'd0;
    localparam logic [2:0] REG_GYRO_Y  = 3'd1;
    localparam logic [2:0] REG_GYRO_Z  = 3'd2;
    localparam logic [2:0] REG_ACCEL_X = 3'd3;
    localparam logic [2:0] REG_ACCEL_Y = 3'd4;
    localparam logic [2:0] REG_ACCEL_Z = 3'd5;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_FIRST   = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    localparam logic signed [15:0] ONE_G      = 16'sd8192;
    localparam logic signed [15:0] SMALL_Z    = 16'sd81;
    localparam logic [10:0]        DIV_CONST  = 11'd1000;
    localparam logic [31:0]        ROUND_HALF = 32'd500;
    // The reciprocal of 1000 is 274877907 / 2^38, split into two 17-bit halves.
    localparam logic signed [17:0] MAGIC_HI   = 18'sd2097;
    localparam logic signed [17:0] MAGIC_LO   = 18'sd19923;
    localparam logic signed [17:0] K_GYRO     = 18'sd64225;
    localparam logic signed [17:0] K_ACCEL    = 18'sd1311;
    localparam logic signed [63:0] BLEND_RND  = 64'sd32768;
    localparam logic signed [26:0] DEG_180    = 27'sd11796480;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_QH   = 11'b00000000010,
        S_QL   = 11'b00000000100,
        S_DR   = 11'b00000001000,
        S_MR   = 11'b00000010000,
        S_MQ   = 11'b00000100000,
        S_CORD = 11'b00001000000,
        S_MULG = 11'b00010000000,
        S_MULA = 11'b00100000000,
        S_SAT  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    function automatic logic signed [26:0] atan_q16(input logic [4:0] idx);
        logic signed [26:0] v;
        case (idx)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117304;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            5'd22: v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/imu_complementary_tilt_filter_unit.sv -----
// Top level of the complementary roll and pitch filter.
// One beat in gives one beat out. The block takes a sample only when idle. An updating
// sample passes the gyro step, the CORDIC iterations and the blend for roll, then for
// pitch, before its result beat is offered: the divisions by 1000 in the gyro step are
// reciprocal multiplications, the divisions and the blend share one multiplier, and the
// CORDIC iterations run for roll then pitch on one set of adders. First and rejected
// samples go straight to the result beat. The result beat is held until taken, after which
// the next sample is accepted.
module imu_complementary_tilt_filter_unit
    import ictf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_us, accel_x_in, accel_y_in, accel_z_in, gyro_x_in, gyro_y_in, gyro_z_in
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_deg, pitch_deg, accel_x_out, accel_y_out, accel_z_out,
    // gyro_x_out, gyro_y_out, gyro_z_out
    output logic [159:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);

    logic signed [15:0] r_bias [NUM_REGS];
    t_state             r_state;
    logic               r_first;
    logic [31:0]        r_last;
    logic signed [31:0] r_roll, r_pitch;
    logic [1:0]         r_status;
    logic signed [16:0] r_ax, r_ay, r_gx, r_gy, r_gz;
    logic signed [15:0] r_caz;
    logic [31:0]        r_dt;
    logic               r_axis;
    logic [5:0]         r_cnt;
    logic [31:0]        r_mq;
    logic [22:0]        r_q;
    logic [22:0]        r_dq;
    logic [9:0]         r_dr;
    logic               r_dtq;
    logic signed [40:0] r_g;
    logic signed [33:0] r_x, r_y;
    logic signed [26:0] r_z;
    logic signed [63:0] r_acc;

    logic [31:0]        in_time;
    logic signed [15:0] in_ax, in_ay, in_az, in_gx, in_gy, in_gz;
    logic signed [17:0] caz_wide;
    logic signed [15:0] caz_new;
    logic               reject;
    logic signed [16:0] gc, ac, gc_abs;
    logic signed [31:0] st_axis;
    logic signed [17:0] mul_a;
    logic signed [41:0] mul_b;
    logic signed [59:0] prod;
    logic signed [63:0] magic;
    logic [39:0]        quo;
    logic signed [40:0] step;
    logic signed [16:0] x_init, y_init;
    logic signed [33:0] xs, ys;
    logic signed [26:0] tab;
    logic signed [43:0] blend_sh;
    logic signed [31:0] blend_sat;
    logic               last_axis, cord_done;

    assign in_time = s_axis_tdata[31:0];
    assign in_ax   = s_axis_tdata[47:32];
    assign in_ay   = s_axis_tdata[63:48];
    assign in_az   = s_axis_tdata[79:64];
    assign in_gx   = s_axis_tdata[95:80];
    assign in_gy   = s_axis_tdata[111:96];
    assign in_gz   = s_axis_tdata[127:112];

    assign caz_wide = 18'(in_az) + 18'(ONE_G) - 18'(r_bias[REG_ACCEL_Z]);
    assign caz_new  = sat16(caz_wide);
    assign reject   = (r_bias[REG_ACCEL_Z] == 16'sd0)
                      || ((caz_new >= -SMALL_Z) && (caz_new <= SMALL_Z));

    assign gc      = r_axis ? r_gy : r_gx;
    assign ac      = r_axis ? r_ay : r_ax;
    assign st_axis = r_axis ? r_pitch : r_roll;
    assign gc_abs  = gc[16] ? -gc : gc;

    always_comb begin
        case (r_state)
            S_QH: begin
                mul_a = MAGIC_HI;
                mul_b = 42'(r_mq);
            end
            S_QL: begin
                mul_a = MAGIC_LO;
                mul_b = 42'(r_mq);
            end
            S_DR: begin
                mul_a = 18'(DIV_CONST);
                mul_b = 42'(r_q);
            end
            S_MR: begin
                mul_a = 18'(gc_abs);
                mul_b = 42'(r_dr);
            end
            S_MQ: begin
                mul_a = 18'(gc_abs);
                mul_b = 42'(r_dq);
            end
            S_MULG: begin
                mul_a = K_GYRO;
                mul_b = 42'(r_g);
            end
            S_MULA: begin
                mul_a = K_ACCEL;
                mul_b = 42'(r_z);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = 60'(mul_a * mul_b);

    assign magic = (r_acc <<< 17) + 64'(prod);

    assign quo  = prod[39:0] + 40'(r_q);
    assign step = gc[16] ? -41'(quo) : 41'(quo);

    assign x_init = (r_caz < 0) ? -17'(r_caz) : 17'(r_caz);
    assign y_init = (r_caz < 0) ? -ac : ac;

    assign xs  = r_x >>> r_cnt[4:0];
    assign ys  = r_y >>> r_cnt[4:0];
    assign tab = atan_q16(r_cnt[4:0]);

    assign blend_sh  = 44'(r_acc >>> 16);
    assign blend_sat = (blend_sh > 44'sh0007FFFFFFF) ? 32'sh7FFFFFFF :
                       (blend_sh < -44'sh00080000000) ? 32'sh80000000 : blend_sh[31:0];

    assign last_axis = r_axis;
    assign cord_done = r_cnt == 6'(CORDIC_STEPS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_bias[k] <= 16'sd0;
            end
            r_bias[REG_ACCEL_Z] <= ONE_G;
        end else if (i_cfg_we && (i_cfg_idx <= REG_ACCEL_Z)) begin
            r_bias[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b1;
            r_last  <= '0;
            r_roll  <= '0;
            r_pitch <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_last <= in_time;
                        r_dt   <= in_time - r_last;
                        r_mq   <= in_time - r_last;
                        r_dtq  <= 1'b1;
                        r_ax   <= 17'(in_ax) - 17'(r_bias[REG_ACCEL_X]);
                        r_ay   <= 17'(in_ay) - 17'(r_bias[REG_ACCEL_Y]);
                        r_gx   <= 17'(in_gx) - 17'(r_bias[REG_GYRO_X]);
                        r_gy   <= 17'(in_gy) - 17'(r_bias[REG_GYRO_Y]);
                        r_gz   <= 17'(in_gz) - 17'(r_bias[REG_GYRO_Z]);
                        r_caz  <= caz_new;
                        r_axis <= 1'b0;
                        if (r_first) begin
                            r_first  <= 1'b0;
                            r_status <= ST_FIRST;
                            r_state  <= S_OUT;
                        end else if (reject) begin
                            r_status <= ST_REJECT;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_UPDATED;
                            r_state  <= S_QH;
                        end
                    end
                end
                S_QH: begin
                    r_acc   <= 64'(prod);
                    r_state <= S_QL;
                end
                S_QL: begin
                    r_q     <= magic[60:38];
                    r_state <= r_dtq ? S_DR : S_MQ;
                end
                S_DR: begin
                    r_dq    <= r_q;
                    r_dr    <= 10'(r_dt - prod[31:0]);
                    r_dtq   <= 1'b0;
                    r_state <= S_MR;
                end
                S_MR: begin
                    r_mq    <= prod[31:0] + ROUND_HALF;
                    r_state <= S_QH;
                end
                S_MQ: begin
                    r_g     <= 41'(st_axis) + step;
                    r_x     <= 34'(x_init) <<< 14;
                    r_y     <= 34'(y_init) <<< 14;
                    r_z     <= (r_caz >= 0) ? 27'sd0 : ((ac >= 0) ? DEG_180 : -DEG_180);
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + tab;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - tab;
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (cord_done) begin
                        r_state <= S_MULG;
                    end
                end
                S_MULG: begin
                    r_acc   <= 64'(prod);
                    r_state <= S_MULA;
                end
                S_MULA: begin
                    r_acc   <= r_acc + 64'(prod) + BLEND_RND;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (last_axis) begin
                        r_pitch <= blend_sat;
                        r_state <= S_OUT;
                    end else begin
                        r_roll  <= blend_sat;
                        r_axis  <= 1'b1;
                        r_state <= S_MR;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic upd;
    assign upd = r_status == ST_UPDATED;

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_state == S_OUT;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {
        upd ? sat16(18'(r_gz)) : 16'sd0,
        upd ? sat16(18'(r_gy)) : 16'sd0,
        upd ? sat16(18'(r_gx)) : 16'sd0,
        upd ? r_caz : 16'sd0,
        upd ? sat16(18'(r_ay)) : 16'sd0,
        upd ? sat16(18'(r_ax)) : 16'sd0,
        r_pitch,
        r_roll
    };

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input and output handshakes overlap");

    a_first_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_FIRST) |-> !r_first)
        else $error("first-sample flag still set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result beat changed while waiting");

    a_angles_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state == S_OUT)) |-> $stable(r_roll) && $stable(r_pitch))
        else $error("angles changed while result held");

endmodule

// ----- tb/sv/tb_imu_complementary_tilt_filter_unit_chk.sv -----
// Watches both streams of the tilt filter, predicts every result beat and compares it.
`timescale 1ns / 1ps

module tb_imu_complementary_tilt_filter_unit_chk
    import ictf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [159:0] i_m_tdata,
    input  logic [1:0]   i_m_tuser,
    output int           o_errors,
    output int           o_pending,
    output int           o_results
);

    typedef struct packed {
        logic [1:0]   status;
        logic [159:0] data;
    } t_tilt_result;

    t_tilt_result     tilt_q[$];
    logic signed [15:0] bias[NUM_REGS];
    logic [31:0]      prev_time;
    logic             first_wait;
    logic signed [31:0] roll_acc;
    logic signed [31:0] pitch_acc;

    localparam longint ATAN_TAB[24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint tilt_atan2(longint y, longint x);
        longint base;
        longint z;
        longint xs;
        longint ys;
        base = 0;
        z = 0;
        if (x < 0) begin
            base = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
            x = -x;
            y = -y;
        end
        x = x * 16384;
        y = y * 16384;
        for (int i = 0; i < CORDIC_DEF; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
        end
        return base + z;
    endfunction

    function automatic longint rate_step(longint gc, logic [31:0] dt);
        longint p;
        p = gc * longint'(dt);
        if (p >= 0) return (p + 500) / 1000;
        return -((-p + 500) / 1000);
    endfunction

    function automatic logic signed [31:0] mix_angle(longint g, longint a);
        longint v;
        v = (64225 * g + 1311 * a + 32768) >>> 16;
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic predict_tilt(input logic [127:0] d);
        t_tilt_result r;
        longint ax, ay, caz, gx, gy, gz, gr, gp;
        logic [31:0] now;
        logic [31:0] dt;
        now = d[31:0];
        ax  = longint'($signed(d[47:32])) - bias[REG_ACCEL_X];
        ay  = longint'($signed(d[63:48])) - bias[REG_ACCEL_Y];
        caz = clip16(longint'($signed(d[79:64])) + 8192 - bias[REG_ACCEL_Z]);
        gx  = longint'($signed(d[95:80])) - bias[REG_GYRO_X];
        gy  = longint'($signed(d[111:96])) - bias[REG_GYRO_Y];
        gz  = longint'($signed(d[127:112])) - bias[REG_GYRO_Z];
        r = '0;
        if (first_wait) begin
            prev_time = now;
            first_wait = 1'b0;
            r.status = ST_FIRST;
        end else begin
            dt = now - prev_time;
            prev_time = now;
            if (bias[REG_ACCEL_Z] == 0 || (caz >= -81 && caz <= 81)) begin
                r.status = ST_REJECT;
            end else begin
                gr = longint'(roll_acc) + rate_step(gx, dt);
                gp = longint'(pitch_acc) + rate_step(gy, dt);
                roll_acc  = mix_angle(gr, tilt_atan2(ax, caz));
                pitch_acc = mix_angle(gp, tilt_atan2(ay, caz));
                r.status = ST_UPDATED;
                r.data[79:64]   = 16'(clip16(ax));
                r.data[95:80]   = 16'(clip16(ay));
                r.data[111:96]  = 16'(caz);
                r.data[127:112] = 16'(clip16(gx));
                r.data[143:128] = 16'(clip16(gy));
                r.data[159:144] = 16'(clip16(gz));
            end
        end
        r.data[31:0]  = roll_acc;
        r.data[63:32] = pitch_acc;
        tilt_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", o_results, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_tilt_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) bias[i] = 0;
            bias[REG_ACCEL_Z] = ONE_G;
            prev_time = 0;
            first_wait = 1'b1;
            roll_acc = 0;
            pitch_acc = 0;
            tilt_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (tilt_q.size() == 0) begin
                    report_mismatch("unexpected beat", {30'd0, i_m_tuser}, 32'd0);
                end else begin
                    e = tilt_q.pop_front();
                    if (i_m_tuser !== e.status)
                        report_mismatch("status", 32'(i_m_tuser), 32'(e.status));
                    for (int f = 0; f < 8; f++) begin
                        if (f < 2) begin
                            if (i_m_tdata[f*32 +: 32] !== e.data[f*32 +: 32])
                                report_mismatch($sformatf("field %0d", f),
                                                i_m_tdata[f*32 +: 32], e.data[f*32 +: 32]);
                        end else if (i_m_tdata[64 + (f-2)*16 +: 16]
                                     !== e.data[64 + (f-2)*16 +: 16]) begin
                            report_mismatch($sformatf("field %0d", f),
                                            32'(i_m_tdata[64 + (f-2)*16 +: 16]),
                                            32'(e.data[64 + (f-2)*16 +: 16]));
                        end
                    end
                end
                o_results++;
            end
            if (i_s_tvalid && i_s_tready) predict_tilt(i_s_tdata);
            if (i_cfg_we && i_cfg_idx < NUM_REGS) bias[i_cfg_idx] = i_cfg_data;
        end
        o_pending = tilt_q.size();
    end

endmodule

// ----- tb/sv/tb_imu_complementary_tilt_filter_unit.sv -----
// Stimulus and verdict for the complementary tilt filter testbench.
`timescale 1ns / 1ps

module tb_imu_complementary_tilt_filter_unit;
    import ictf_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           errors;
    int           pending;
    int           results;
    int           send_idle = 0;
    int           recv_stall = 0;
    int           sent = 0;
    logic [31:0]  clock_us = 0;

    imu_complementary_tilt_filter_unit uut (.*);

    tb_imu_complementary_tilt_filter_unit_chk chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_m_tuser(m_axis_tuser), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic write_bias(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_filter();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [127:0] d);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [15:0] near_val(input int centre, input int spread);
        return 16'(centre + $signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic send_tilted(input int step_us, input bit wild);
        logic [127:0] d;
        clock_us = clock_us + step_us;
        d[31:0] = clock_us;
        if (wild) begin
            d[127:32] = {$urandom, $urandom, $urandom};
        end else begin
            d[47:32]   = near_val(0, 6000);
            d[63:48]   = near_val(0, 6000);
            d[79:64]   = near_val(8192, 3000);
            d[95:80]   = near_val(0, 3000);
            d[111:96]  = near_val(0, 3000);
            d[127:112] = 16'($urandom);
        end
        send_sample(d);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first sample, extremes, small and negative z, wrap of time.
        send_sample({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd8192, 16'sd0, 16'sd0, 32'd100});
        send_sample({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                     32'd1100});
        send_sample({16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF,
                     32'hFFFF_FFFF});
        send_sample({16'd0, 16'd0, 16'd0, -16'sd8111, 16'd0, 16'd0, 32'd900});
        send_sample({16'd0, 16'd0, 16'd0, -16'sd8110, 16'd0, 16'd0, 32'd1900});
        send_sample({16'd0, 16'd0, 16'd0, -16'sd8273, 16'd0, 16'd0, 32'd2900});
        send_sample({16'd0, 16'd0, 16'd0, -16'sd8274, 16'd0, 16'd0, 32'd3900});
        send_sample({16'd5, 16'd5, 16'd5, -16'sd9000, 16'd0, -16'sd300, 32'd4900});
        send_sample({16'd5, 16'd5, 16'd5, -16'sd9000, -16'sd1, 16'sd300, 32'd5900});
        send_sample({16'hFFFF, 16'h0, 16'h0, 16'd8192, 16'h0, 16'h0, 32'hFFFF_FF00});
        drain_filter();

        write_bias(REG_ACCEL_Z, 16'd0);
        write_bias(3'd7, 16'h1234);
        send_sample({16'd1, 16'd1, 16'd1, 16'd8192, 16'd1, 16'd1, 32'd7000});
        drain_filter();
        write_bias(REG_GYRO_X, 16'h7FFF);
        write_bias(REG_GYRO_Y, 16'h8000);
        write_bias(REG_GYRO_Z, 16'h8000);
        write_bias(REG_ACCEL_X, 16'h7FFF);
        write_bias(REG_ACCEL_Y, 16'h8000);
        write_bias(REG_ACCEL_Z, 16'h8000);
        send_sample({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd8000});
        send_sample({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'd9000});
        drain_filter();

        for (int ph = 0; ph < 8; ph++) begin
            send_idle  = (ph % 4 == 1) ? 46 : (ph % 4 == 3) ? 18 : 0;
            recv_stall = (ph % 4 == 2) ? 46 : (ph % 4 == 3) ? 18 : 0;
            if (ph == 0) begin
                for (int r = 0; r < NUM_REGS; r++) write_bias(3'(r), 16'd0);
                write_bias(REG_ACCEL_Z, ONE_G);
            end else if (ph == 4) begin
                write_bias(REG_ACCEL_Z, 16'h7FFF);
            end else begin
                for (int r = 0; r < NUM_REGS - 1; r++) write_bias(3'(r), near_val(0, 400));
                write_bias(REG_ACCEL_Z, near_val(8192, 600));
            end
            for (int k = 0; k < 92; k++) begin
                send_tilted(($urandom_range(9) == 0) ? $urandom : $urandom_range(2000),
                            $urandom_range(9) < 2);
                if (k == 45) drain_filter();
            end
            drain_filter();
        end

        $display("covered %0d samples over eight bias settings and four flow regimes", sent);
        $display("checked %0d result beats", results);
        if (errors == 0) begin
            $display("tb_imu_complementary_tilt_filter_unit OK");
        end else begin
            $display("tb_imu_complementary_tilt_filter_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_imu_complementary_tilt_filter_unit NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ictf_pkg.sv
hdl/imu_complementary_tilt_filter_unit.sv
tb/sv/tb_imu_complementary_tilt_filter_unit_chk.sv
tb/sv/tb_imu_complementary_tilt_filter_unit.sv
